FILE: src/pwmpd_pkg.sv
package pwmpd_pkg;

   localparam int TIME_W = 16;
   localparam int PCT_W = 7;
   localparam int COUNT_W = 7;
   localparam int CODE_W = 64;
   localparam int TOL_W = 17;
   localparam int PROD_W = TIME_W + PCT_W;
   localparam int RECIP_W = 24;
   localparam int RECIP_SHIFT = 30;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 16;

   // Reciprocal of 100 scaled by two to the RECIP_SHIFT, rounded up; exact for PROD_W-bit inputs.
   localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

   localparam logic [1:0] SETTLE_CYCLES = 2'd2;
   localparam logic [COUNT_W-1:0] CODE_BIT_CAP = 7'd64;

   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_TIME = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_TIME = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE_PCT = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BITS_NEEDED = 8'd3;

   localparam logic [TIME_W-1:0] RESET_SHORT_TIME = 16'd400;
   localparam logic [TIME_W-1:0] RESET_LONG_TIME = 16'd800;
   localparam logic [PCT_W-1:0] RESET_TOLERANCE_PCT = 7'd20;
   localparam logic [COUNT_W-1:0] RESET_BITS_NEEDED = 7'd64;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] high_time;
      logic [TIME_W-1:0] low_time;
      logic start_of_burst;
      logic last_pair;
   } req_payload_type;

   typedef struct packed {
      logic status;
      logic [CODE_W-1:0] code_word;
      logic [27:0] serial_number;
      logic [3:0] button_id;
      logic [31:0] rolling_code;
      logic [COUNT_W-1:0] bit_length;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_payload_type;

   typedef struct packed {
      logic [TOL_W-1:0] tol_short;
      logic [TOL_W-1:0] tol_long;
      logic settling;
   } tol_status_type;

endpackage

FILE: src/pwmpd_stream_if.sv
interface pwmpd_stream_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/pwmpd_tolerance.sv
module pwmpd_tolerance
   import pwmpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic [TIME_W-1:0] short_time,
   input  logic [TIME_W-1:0] long_time,
   input  logic [PCT_W-1:0] tolerance_pct,
   input  logic cfg_write,
   output tol_status_type tol_status
);

   logic [PROD_W-1:0] prod_short_ff, prod_short_in;
   logic [PROD_W-1:0] prod_long_ff, prod_long_in;
   logic [TOL_W-1:0] tol_short_ff, tol_short_in;
   logic [TOL_W-1:0] tol_long_ff, tol_long_in;
   logic [1:0] settle_ff, settle_in;
   logic [PROD_W+RECIP_W-1:0] quot_short;
   logic [PROD_W+RECIP_W-1:0] quot_long;

   assign prod_short_in = PROD_W'(short_time) * PROD_W'(tolerance_pct);
   assign prod_long_in = PROD_W'(long_time) * PROD_W'(tolerance_pct);

   assign quot_short = (PROD_W+RECIP_W)'(prod_short_ff) * (PROD_W+RECIP_W)'(RECIP_100);
   assign quot_long = (PROD_W+RECIP_W)'(prod_long_ff) * (PROD_W+RECIP_W)'(RECIP_100);
   assign tol_short_in = quot_short[RECIP_SHIFT +: TOL_W];
   assign tol_long_in = quot_long[RECIP_SHIFT +: TOL_W];

   always_comb begin
      if (cfg_write) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_short_ff <= prod_short_in;
      prod_long_ff <= prod_long_in;
      tol_short_ff <= tol_short_in;
      tol_long_ff <= tol_long_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign tol_status.tol_short = tol_short_ff;
   assign tol_status.tol_long = tol_long_ff;
   assign tol_status.settling = (settle_ff != 2'd0);

endmodule

FILE: src/pwm_pulse_pair_bit_decoder_core.sv
// Channel  Role    Payload                                              Transfer when
// req_chan sink    high_time, low_time, start_of_burst, last_pair       valid && ready
// rsp_chan source  status, code_word, serial_number, button_id, ...    valid && ready
// csr_chan sink    reg_index, wdata                                     valid && ready
//
// A pulse pair is taken per cycle unless a stall or settling holds it; any result is registered.
// The pair sits in an input register, then one pass of compare logic updates the decoder state.
// A register write makes req_chan.ready low while the tolerances are recomputed.
// After reset, req_chan.ready stays low for the same reason.
// A stalled result holds the pipeline; one more pair is still taken into the input register.
module pwm_pulse_pair_bit_decoder_core
   import pwmpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pwmpd_stream_if.sink req_chan,
   pwmpd_stream_if.source rsp_chan,
   pwmpd_stream_if.sink csr_chan
);

   logic [TIME_W-1:0] short_time_ff;
   logic [TIME_W-1:0] long_time_ff;
   logic [PCT_W-1:0] tolerance_pct_ff;
   logic [COUNT_W-1:0] bits_needed_ff;
   logic cfg_write;
   tol_status_type tol_status;

   logic s1_valid_ff, s1_valid_in;
   req_payload_type s1_item_ff;
   logic [CODE_W-1:0] shift_code_ff, shift_code_in;
   logic [COUNT_W-1:0] bit_counter_ff, bit_counter_in;
   logic burst_active_ff, burst_active_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_status_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic [COUNT_W-1:0] rsp_length_ff;

   logic req_take;
   logic advance;
   logic step;
   logic load;
   logic [COUNT_W-1:0] need;
   logic [CODE_W-1:0] code0, code1, res_code;
   logic [COUNT_W-1:0] cnt0, cnt1, res_cnt;
   logic act0;
   logic [TIME_W-1:0] gap_hs, gap_hl, gap_ls, gap_ll;
   logic match0, match1;
   logic emit, ok;

   assign cfg_write = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_time_ff <= RESET_SHORT_TIME;
         long_time_ff <= RESET_LONG_TIME;
         tolerance_pct_ff <= RESET_TOLERANCE_PCT;
         bits_needed_ff <= RESET_BITS_NEEDED;
      end else if (cfg_write) begin
         case (csr_chan.payload.reg_index)
            REG_SHORT_TIME: short_time_ff <= csr_chan.payload.wdata;
            REG_LONG_TIME: long_time_ff <= csr_chan.payload.wdata;
            REG_TOLERANCE_PCT: tolerance_pct_ff <= csr_chan.payload.wdata[PCT_W-1:0];
            REG_BITS_NEEDED: bits_needed_ff <= csr_chan.payload.wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   pwmpd_tolerance u_tolerance (
      .clock(clock),
      .reset(reset),
      .short_time(short_time_ff),
      .long_time(long_time_ff),
      .tolerance_pct(tolerance_pct_ff),
      .cfg_write(cfg_write),
      .tol_status(tol_status)
   );

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign step = s1_valid_ff && advance;
   assign req_chan.ready = (!s1_valid_ff || advance) && !tol_status.settling;
   assign req_take = req_chan.valid && req_chan.ready;
   assign s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   assign need = (bits_needed_ff > CODE_BIT_CAP) ? CODE_BIT_CAP : bits_needed_ff;
   assign code0 = s1_item_ff.start_of_burst ? '0 : shift_code_ff;
   assign cnt0 = s1_item_ff.start_of_burst ? '0 : bit_counter_ff;
   assign act0 = s1_item_ff.start_of_burst || burst_active_ff;
   assign cnt1 = cnt0 + 7'd1;
   assign code1 = {code0[CODE_W-2:0], match1 && !match0};

   assign gap_hs = (s1_item_ff.high_time >= short_time_ff) ?
                   s1_item_ff.high_time - short_time_ff : short_time_ff - s1_item_ff.high_time;
   assign gap_hl = (s1_item_ff.high_time >= long_time_ff) ?
                   s1_item_ff.high_time - long_time_ff : long_time_ff - s1_item_ff.high_time;
   assign gap_ls = (s1_item_ff.low_time >= short_time_ff) ?
                   s1_item_ff.low_time - short_time_ff : short_time_ff - s1_item_ff.low_time;
   assign gap_ll = (s1_item_ff.low_time >= long_time_ff) ?
                   s1_item_ff.low_time - long_time_ff : long_time_ff - s1_item_ff.low_time;

   assign match0 = ({1'b0, gap_hs} < tol_status.tol_short) &&
                   ({1'b0, gap_ll} < tol_status.tol_long);
   assign match1 = ({1'b0, gap_hl} < tol_status.tol_long) &&
                   ({1'b0, gap_ls} < tol_status.tol_short);

   always_comb begin
      shift_code_in = shift_code_ff;
      bit_counter_in = bit_counter_ff;
      burst_active_in = burst_active_ff;
      emit = 1'b0;
      ok = 1'b0;
      res_code = code0;
      res_cnt = cnt0;
      if (step) begin
         shift_code_in = code0;
         bit_counter_in = cnt0;
         burst_active_in = act0;
         if (act0) begin
            if (cnt0 >= need) begin
               emit = 1'b1;
               ok = 1'b1;
            end else if (match0 || match1) begin
               shift_code_in = code1;
               bit_counter_in = cnt1;
               res_code = code1;
               res_cnt = cnt1;
               if (cnt1 >= need) begin
                  emit = 1'b1;
                  ok = 1'b1;
               end else if (s1_item_ff.last_pair) begin
                  emit = 1'b1;
               end
            end else begin
               emit = 1'b1;
            end
         end
         if (emit) begin
            burst_active_in = 1'b0;
         end
      end
   end

   assign load = step && emit;
   assign rsp_valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         shift_code_ff <= '0;
         bit_counter_ff <= '0;
         burst_active_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_code_ff <= shift_code_in;
         bit_counter_ff <= bit_counter_in;
         burst_active_ff <= burst_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_chan.payload;
      end
      if (load) begin
         rsp_status_ff <= ok ? STATUS_OK : STATUS_FAIL;
         rsp_code_ff <= ok ? res_code : '0;
         rsp_length_ff <= ok ? res_cnt : '0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload.status = rsp_status_ff;
   assign rsp_chan.payload.code_word = rsp_code_ff;
   assign rsp_chan.payload.serial_number = rsp_code_ff[31:4];
   assign rsp_chan.payload.button_id = rsp_code_ff[3:0];
   assign rsp_chan.payload.rolling_code = rsp_code_ff[63:32];
   assign rsp_chan.payload.bit_length = rsp_length_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_FAIL) |-> (rsp_code_ff == '0) &&
      (rsp_length_ff == '0))
      else $error("A failed decode carries a nonzero code or length.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_OK) |-> (rsp_length_ff >= need))
      else $error("A successful decode carries fewer bits than required.");

   assert property (@(posedge clock) disable iff (reset)
      load |=> !burst_active_ff)
      else $error("The decoder stays armed after a result.");

   assert property (@(posedge clock) disable iff (reset)
      tol_status.settling |-> !req_chan.ready)
      else $error("A pair is taken while the tolerances are being recomputed.");

   assert property (@(posedge clock) disable iff (reset)
      bit_counter_ff <= CODE_BIT_CAP)
      else $error("The bit counter runs past the code width.");

endmodule
